### rtl/lod_node_score_core_assert.svh
// Assertion macros shared by the node scorer RTL.
`ifndef LOD_NODE_SCORE_CORE_ASSERT_SVH
`define LOD_NODE_SCORE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LNS_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define LNS_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### rtl/lns_pkg.sv
// Types, codes and constant functions of the node scorer.
package lns_pkg;

  // request and result payloads
  typedef struct packed {
    logic               opcode;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [31:0]        area;
    logic               is_leaf;
  } lns_in_t;

  typedef struct packed {
    logic [47:0] score;
    logic [47:0] range_low;
    logic [47:0] range_high;
    logic        saturated;
  } lns_out_t;

  // opcode values
  localparam logic OPC_SCORE = 1'b0;
  localparam logic OPC_RESET = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT_SQ = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT_INV = 3'd4;

  localparam logic [63:0] NEAR_LIMIT_SQ_RST  = 64'd9663676416;
  localparam logic [47:0] NEAR_LIMIT_INV_RST = 48'd1908874354;
  localparam logic [47:0] SCORE_MAX          = 48'hFFFF_FFFF_FFFF;
  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;

  // first and last step values of the iterative phases
  localparam logic [6:0] SQRT_FIRST = 7'd21;  // root bit 2^42 down to 2^0
  localparam logic [6:0] QDIV_FIRST = 7'd14;  // direction quotient, 15 bits
  localparam logic [6:0] DIV_FIRST  = 7'd81;  // dividend t*2^32 is below 2^82
  localparam logic [6:0] MUL_LAST   = 7'd3;   // four partial products
  localparam logic [6:0] AXIS_LAST  = 7'd2;

  // datapath operations
  localparam logic [3:0] OP_NOP  = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_SQ   = 4'd2;
  localparam logic [3:0] OP_LEN  = 4'd3;
  localparam logic [3:0] OP_DOT  = 4'd4;
  localparam logic [3:0] OP_SQRT = 4'd5;
  localparam logic [3:0] OP_QCHK = 4'd6;
  localparam logic [3:0] OP_QDIV = 4'd7;
  localparam logic [3:0] OP_DP   = 4'd8;
  localparam logic [3:0] OP_EXP  = 4'd9;
  localparam logic [3:0] OP_AREA = 4'd10;
  localparam logic [3:0] OP_CMP  = 4'd11;
  localparam logic [3:0] OP_DIV  = 4'd12;
  localparam logic [3:0] OP_MUL  = 4'd13;
  localparam logic [3:0] OP_FIN  = 4'd14;

  typedef struct packed {
    logic [3:0] op;
    logic [6:0] step;
  } lns_cmd_t;

  typedef struct packed {
    logic m_zero;    // node center equals camera
    logic q_big;     // direction quotient beyond one
    logic near;      // inside the near limit
    logic out_busy;  // output register held this cycle
  } lns_sts_t;

  // shift-subtract division, used only at elaboration
  function automatic logic [63:0] lns_udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^(-1 + 2i/depth) in Q2.30, Taylor series in Q.48
  function automatic logic [31:0] lns_exp_entry(input int unsigned i, input int unsigned depth);
    logic        neg;
    logic [63:0] an;
    logic [63:0] den;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] rnd;
    neg  = (2 * i) < depth;
    an   = neg ? 64'(depth - 2 * i) : 64'(2 * i - depth);
    den  = 64'(depth);
    sum  = 64'd1 << 48;
    term = 64'd1 << 48;
    for (int k = 1; k < 64; k++) begin
      if (term != 64'd0) begin
        term = lns_udiv(term * an, den * 64'(k));
        if (neg && (k % 2 == 1)) sum = sum - term;
        else sum = sum + term;
      end
    end
    rnd = (sum + (64'd1 << 17)) >> 18;
    return rnd[31:0];
  endfunction

endpackage

### rtl/lns_ctrl.sv
// Sequencer that steps the scorer datapath through one request.
module lns_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_opcode_i,
  output logic              in_ready_o,
  input  lns_pkg::lns_sts_t sts_i,
  output lns_pkg::lns_cmd_t cmd_o
);
  import lns_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_LEN  = 4'd2;
  localparam logic [3:0] S_DOT  = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_QCHK = 4'd5;
  localparam logic [3:0] S_QDIV = 4'd6;
  localparam logic [3:0] S_DP   = 4'd7;
  localparam logic [3:0] S_EXP  = 4'd8;
  localparam logic [3:0] S_AREA = 4'd9;
  localparam logic [3:0] S_CMP  = 4'd10;
  localparam logic [3:0] S_DIV  = 4'd11;
  localparam logic [3:0] S_MUL  = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;

  logic [3:0] state_q, state_d;
  logic [6:0] cnt_q, cnt_d;

  // next state and command
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = OP_NOP;
    cmd_o.step = cnt_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          cnt_d    = '0;
          state_d  = (in_opcode_i == OPC_RESET) ? S_FIN : S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.op = OP_SQ;
        if (cnt_q == AXIS_LAST) begin
          cnt_d   = '0;
          state_d = S_LEN;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      S_LEN: begin
        if (sts_i.m_zero) begin
          state_d = S_DP;
        end else begin
          cmd_o.op = OP_LEN;
          if (cnt_q == AXIS_LAST) begin
            cnt_d   = '0;
            state_d = S_DOT;
          end else begin
            cnt_d = cnt_q + 7'd1;
          end
        end
      end
      S_DOT: begin
        cmd_o.op = OP_DOT;
        if (cnt_q == AXIS_LAST) begin
          cnt_d   = SQRT_FIRST;
          state_d = S_SQRT;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (cnt_q == '0) state_d = S_QCHK;
        else cnt_d = cnt_q - 7'd1;
      end
      S_QCHK: begin
        cmd_o.op = OP_QCHK;
        cnt_d    = QDIV_FIRST;
        state_d  = S_QDIV;
      end
      S_QDIV: begin
        if (sts_i.q_big) begin
          state_d = S_DP;
        end else begin
          cmd_o.op = OP_QDIV;
          if (cnt_q == '0) state_d = S_DP;
          else cnt_d = cnt_q - 7'd1;
        end
      end
      S_DP: begin
        cmd_o.op = OP_DP;
        state_d  = S_EXP;
      end
      S_EXP: begin
        cmd_o.op = OP_EXP;
        state_d  = S_AREA;
      end
      S_AREA: begin
        cmd_o.op = OP_AREA;
        state_d  = S_CMP;
      end
      S_CMP: begin
        cmd_o.op = OP_CMP;
        cnt_d    = DIV_FIRST;
        state_d  = S_DIV;
      end
      S_DIV: begin
        if (sts_i.near) begin
          cnt_d   = '0;
          state_d = S_MUL;
        end else begin
          cmd_o.op = OP_DIV;
          if (cnt_q == '0) state_d = S_FIN;
          else cnt_d = cnt_q - 7'd1;
        end
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        if (cnt_q == MUL_LAST) state_d = S_FIN;
        else cnt_d = cnt_q + 7'd1;
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_FIN;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

`include "lod_node_score_core_assert.svh"

  `LNS_ASSERT_IMP(a_div_cnt, state_q == S_DIV, cnt_q <= DIV_FIRST, "divide step out of range")
  `LNS_ASSERT_NXT(a_fin_idle, cmd_o.op == OP_FIN, state_q == S_IDLE, "finish did not return idle")

endmodule

### rtl/lns_dp.sv
// Scorer datapath: distance, direction, exp lookup, divide/multiply, range.
module lns_dp #(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lns_pkg::lns_cmd_t  cmd_i,
  output lns_pkg::lns_sts_t  sts_o,
  input  lns_pkg::lns_in_t   in_data_i,
  input  logic signed [31:0] cam_x_i,
  input  logic signed [31:0] cam_y_i,
  input  logic signed [31:0] cam_z_i,
  input  logic [63:0]        near_sq_i,
  input  logic [47:0]        near_inv_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lns_pkg::lns_out_t  out_data_o
);
  import lns_pkg::*;

  localparam int unsigned IW = $clog2(EXP_TABLE_DEPTH + 1);

  // exp table, built at elaboration
  logic [31:0] exp_rom [EXP_TABLE_DEPTH+1];
  for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [31:0] Entry = lns_exp_entry(gi, EXP_TABLE_DEPTH);
    assign exp_rom[gi] = Entry;
  end

  lns_in_t            in_q;
  logic [31:0]        mag_q [3];
  logic               dneg_q [3];
  logic [15:0]        nmag_q [3];
  logic               nneg_q [3];
  logic [65:0]        dist_q;
  logic [31:0]        m_q;
  logic [41:0]        len2_q;
  logic signed [38:0] s_q;
  logic [41:0]        x_q;
  logic [42:0]        rt_q;
  logic [37:0]        rem1_q;
  logic [14:0]        sm_q;
  logic               big_q;
  logic [IW-1:0]      idx_q;
  logic [31:0]        entry_q;
  logic [49:0]        t_q;
  logic               near_q, dsat_q, dvsat_q;
  logic [63:0]        rem_q;
  logic [47:0]        qd_q;
  logic [97:0]        acc_q;
  logic [47:0]        lmin_q, lmax_q;
  logic               out_valid_q;
  lns_out_t           out_q;

  // differences to the camera at load
  logic signed [32:0] dv [3];
  logic signed [31:0] cam [3];
  logic signed [31:0] ctr [3];
  logic signed [15:0] nrm [3];
  always_comb begin
    cam[0] = cam_x_i; cam[1] = cam_y_i; cam[2] = cam_z_i;
    ctr[0] = in_data_i.center_x; ctr[1] = in_data_i.center_y; ctr[2] = in_data_i.center_z;
    nrm[0] = in_data_i.normal_x; nrm[1] = in_data_i.normal_y; nrm[2] = in_data_i.normal_z;
    for (int a = 0; a < 3; a++) begin
      dv[a] = {cam[a][31], cam[a]} - {ctr[a][31], ctr[a]};
    end
  end

  // reduction shift so the largest magnitude fits 20 bits
  logic [3:0] k;
  always_comb begin
    k = '0;
    for (int i = 20; i < 32; i++) begin
      if (m_q[i]) k = 4'(i - 19);
    end
  end

  logic [1:0]  axis;
  logic [19:0] r_sel;
  assign axis  = cmd_i.step[1:0];
  assign r_sel = 20'(mag_q[axis] >> k);

  // shared 32x32 multiplier
  logic [31:0] ma, mb;
  logic [63:0] prod;
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd_i.op)
      OP_SQ: begin
        ma = mag_q[axis];
        mb = mag_q[axis];
      end
      OP_LEN: begin
        ma = 32'(r_sel);
        mb = 32'(r_sel);
      end
      OP_DOT: begin
        ma = 32'(r_sel);
        mb = 32'(nmag_q[axis]);
      end
      OP_AREA: begin
        ma = in_q.area;
        mb = entry_q;
      end
      OP_MUL: begin
        unique case (axis)
          2'd0: begin ma = t_q[31:0];        mb = near_inv_i[31:0]; end
          2'd1: begin ma = 32'(t_q[49:32]);  mb = near_inv_i[31:0]; end
          2'd2: begin ma = t_q[31:0];        mb = 32'(near_inv_i[47:32]); end
          default: begin ma = 32'(t_q[49:32]); mb = 32'(near_inv_i[47:32]); end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end
  assign prod = ma * mb;

  // square root step
  logic [42:0] bitv, trial;
  assign bitv  = 43'd1 << {cmd_i.step[4:0], 1'b0};
  assign trial = rt_q + bitv;

  // direction quotient pieces
  logic        s_neg;
  logic [37:0] abs_s;
  logic [20:0] len21;
  logic [35:0] lim;
  logic [37:0] qdvs;
  assign s_neg = s_q[38];
  assign abs_s = s_neg ? 38'(-s_q) : 38'(s_q);
  assign len21 = rt_q[20:0];
  assign lim   = {len21, 15'd0} - 36'({len21, 14'd0}) + 36'(len21);
  assign qdvs  = 38'(len21) << cmd_i.step[3:0];

  // dot product, clamped, and table index
  logic signed [15:0] nx, dpv;
  logic [15:0]        dmag, upos;
  logic [31:0]        isum;
  always_comb begin
    nx = in_q.normal_x;
    if (m_q == '0) begin
      if (nx > ONE_Q14) dpv = ONE_Q14;
      else if (nx < -ONE_Q14) dpv = -ONE_Q14;
      else dpv = nx;
      dmag = '0;
    end else begin
      dmag = big_q ? 16'(ONE_Q14) : 16'(sm_q);
      dpv  = s_neg ? -$signed(dmag) : $signed(dmag);
    end
    upos = 16'(dpv + ONE_Q14);
    isum = 32'(upos) * 32'(EXP_TABLE_DEPTH) + 32'd16384;
  end

  // wide divide step
  logic [63:0] rsh;
  logic        tbit, dtake;
  logic [6:0]  tpos;
  assign tpos  = cmd_i.step - 7'd32;
  assign tbit  = (cmd_i.step >= 7'd32) ? t_q[tpos[5:0]] : 1'b0;
  assign rsh   = {rem_q[62:0], tbit};
  assign dtake = rem_q[63] || (rsh >= dist_q[63:0]);

  // final score
  logic [47:0] score_f, nmin, nmax;
  logic        movf, sat_f;
  always_comb begin
    movf    = acc_q[97:80] != '0;
    score_f = near_q ? (movf ? SCORE_MAX : acc_q[79:32]) : (dvsat_q ? SCORE_MAX : qd_q);
    sat_f   = dsat_q | (near_q ? movf : dvsat_q);
    nmin    = lmin_q;
    nmax    = lmax_q;
    if (in_q.is_leaf) begin
      if (score_f < lmin_q) nmin = score_f;
      if (score_f > lmax_q) nmax = score_f;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        in_q   <= in_data_i;
        dist_q <= '0;
        m_q    <= '0;
        len2_q <= '0;
        s_q    <= '0;
        for (int a = 0; a < 3; a++) begin
          dneg_q[a] <= dv[a][32];
          mag_q[a]  <= dv[a][32] ? 32'(-dv[a]) : dv[a][31:0];
          nneg_q[a] <= nrm[a][15];
          nmag_q[a] <= nrm[a][15] ? 16'(-nrm[a]) : 16'(nrm[a]);
        end
      end
      OP_SQ: begin
        dist_q <= dist_q + 66'(prod);
        if (mag_q[axis] > m_q) m_q <= mag_q[axis];
      end
      OP_LEN: len2_q <= len2_q + 42'(prod);
      OP_DOT: begin
        if (dneg_q[axis] ^ nneg_q[axis]) s_q <= s_q - 39'(prod[36:0]);
        else s_q <= s_q + 39'(prod[36:0]);
        if (axis == 2'd0) begin
          x_q  <= len2_q;
          rt_q <= '0;
        end
      end
      OP_SQRT: begin
        if ({1'b0, x_q} >= trial) begin
          x_q  <= 42'({1'b0, x_q} - trial);
          rt_q <= (rt_q >> 1) + bitv;
        end else begin
          rt_q <= rt_q >> 1;
        end
      end
      OP_QCHK: begin
        big_q  <= abs_s >= 38'(lim);
        rem1_q <= abs_s;
        sm_q   <= '0;
      end
      OP_QDIV: begin
        if (rem1_q >= qdvs) begin
          rem1_q <= rem1_q - qdvs;
          sm_q[cmd_i.step[3:0]] <= 1'b1;
        end
      end
      OP_DP:   idx_q   <= IW'(isum >> 15);
      OP_EXP:  entry_q <= exp_rom[idx_q];
      OP_AREA: t_q     <= prod[63:14];
      OP_CMP: begin
        dsat_q  <= dist_q[65:64] != '0;
        dvsat_q <= dist_q[65:64] != '0;
        near_q  <= !((dist_q[65:64] != '0 ? 64'hFFFF_FFFF_FFFF_FFFF : dist_q[63:0])
                     > near_sq_i);
        if (dist_q[65:64] != '0) dist_q <= 66'(64'hFFFF_FFFF_FFFF_FFFF);
        rem_q   <= '0;
        qd_q    <= '0;
        acc_q   <= '0;
      end
      OP_DIV: begin
        if (dtake) begin
          rem_q <= rsh - dist_q[63:0];
          if (cmd_i.step >= 7'd48) dvsat_q <= 1'b1;
          else qd_q[cmd_i.step[5:0]] <= 1'b1;
        end else begin
          rem_q <= rsh;
        end
      end
      OP_MUL: begin
        unique case (axis)
          2'd0:    acc_q <= acc_q + 98'(prod);
          2'd3:    acc_q <= acc_q + (98'(prod) << 64);
          default: acc_q <= acc_q + (98'(prod) << 32);
        endcase
      end
      default: ;
    endcase
  end

  // leaf range and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lmin_q      <= SCORE_MAX;
      lmax_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_FIN) begin
        out_valid_q <= 1'b1;
        if (in_q.opcode == OPC_RESET) begin
          lmin_q <= SCORE_MAX;
          lmax_q <= '0;
        end else begin
          lmin_q <= nmin;
          lmax_q <= nmax;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FIN) begin
      if (in_q.opcode == OPC_RESET) begin
        out_q <= '{score: '0, range_low: SCORE_MAX, range_high: '0, saturated: 1'b0};
      end else begin
        out_q <= '{score: score_f, range_low: nmin, range_high: nmax, saturated: sat_f};
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;
  assign sts_o.m_zero   = m_q == '0;
  assign sts_o.q_big    = big_q;
  assign sts_o.near     = near_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

`include "lod_node_score_core_assert.svh"

  `LNS_ASSERT_NXT(a_reset_zero, cmd_i.op == OP_FIN && in_q.opcode == OPC_RESET,
                  out_valid_q && out_q.score == '0 && !out_q.saturated, "reset request scored")

endmodule

### rtl/lod_node_score_core.sv
// Top level of the level-of-detail node scorer.
// Each request scores one mesh node or clears the leaf score range, and gives
// one result. A score request beyond the near limit runs 3 distance squares,
// 6 direction products, 22 square-root steps, up to 15 direction-quotient
// steps and 82 steps of the bit-serial score divider; inside the near limit,
// four partial products replace the divider. A zero distance skips the
// direction work. A range-clear request goes straight to the finish step.
// One 32x32 multiplier is shared by all products. A new request is taken
// while the previous result still sits in the output register.
module lod_node_score_core #(
  parameter int unsigned EXP_TABLE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lns_pkg::lns_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lns_pkg::lns_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lns_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]                   cfg_wdata_i
);
  import lns_pkg::*;

  logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
  logic [63:0]        near_sq_q;
  logic [47:0]        near_inv_q;
  lns_cmd_t           cmd;
  lns_sts_t           sts;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q    <= '0;
      cam_y_q    <= '0;
      cam_z_q    <= '0;
      near_sq_q  <= NEAR_LIMIT_SQ_RST;
      near_inv_q <= NEAR_LIMIT_INV_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CAMERA_X:       cam_x_q    <= cfg_wdata_i[31:0];
        CFG_CAMERA_Y:       cam_y_q    <= cfg_wdata_i[31:0];
        CFG_CAMERA_Z:       cam_z_q    <= cfg_wdata_i[31:0];
        CFG_NEAR_LIMIT_SQ:  near_sq_q  <= cfg_wdata_i;
        CFG_NEAR_LIMIT_INV: near_inv_q <= cfg_wdata_i[47:0];
        default: ;
      endcase
    end
  end

  lns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lns_dp #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cam_x_i     (cam_x_q),
    .cam_y_i     (cam_y_q),
    .cam_z_i     (cam_z_q),
    .near_sq_i   (near_sq_q),
    .near_inv_i  (near_inv_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`include "lod_node_score_core_assert.svh"

  `LNS_ASSERT_NXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o,
                  "second request taken while busy")

endmodule
